@@ hdl/assert_macros.svh @@
// Assertion macros for the wall force pipeline.
// Expects clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define LEWRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LEWRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lewrf_pkg.sv @@
// Shared constants and types for the log/exp wall force pipeline.
// No dependencies.
package lewrf_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] C18_Q30 = 31'd1932735283;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;

	localparam int LOG_LAT = 32;
	localparam int EXP_LAT = 85;
	localparam int MUL_LAT = 3;

	localparam int MUL_W = 48;
	localparam int MUL_HALF = MUL_W / 2;

	localparam int KD_W = 62 - FRAC_BITS;
	localparam int KR_W = 52 - FRAC_BITS;

	typedef enum logic [1:0] {
		REG_SPRING_STIFFNESS = 2'd0,
		REG_WALL_RADIUS      = 2'd1,
		REG_CELL_RADIUS      = 2'd2
	} lewrf_reg_t;

endpackage

@@ hdl/log_exp_wall_restoring_force.sv @@
// One item per cycle while the pipeline is not stalled.
// Throughput set by the fully pipelined divider, squaring and Taylor stages.
// The pipeline stalls only when the output register holds a result that is not
// taken and a valid item waits behind it; bubbles ahead of a held result still move.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the
// register defaults k = 15.0, wall radius = 0.1, cell radius = 0.5.
`include "assert_macros.svh"

module log_exp_wall_restoring_force (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] position_x
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] force_x
	output logic [0:0]  m_axis_tuser,   // [0] domain_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int MW      = lewrf_pkg::MUL_W;
	localparam int KDW     = lewrf_pkg::KD_W;
	localparam int KRW     = lewrf_pkg::KR_W;
	localparam int FB      = lewrf_pkg::FRAC_BITS;
	localparam int S_LOG   = 1 + lewrf_pkg::LOG_LAT + 1 + 2 * lewrf_pkg::MUL_LAT + 1;
	localparam int S_FINAL = 3 + lewrf_pkg::EXP_LAT + lewrf_pkg::MUL_LAT + 1;
	localparam int FLG_DLY = S_FINAL - 1;
	localparam int LOG_DLY = S_FINAL - S_LOG;
	localparam int KD_DLY  = lewrf_pkg::EXP_LAT;

	logic [30:0] k_q;
	logic [19:0] wr_q, cr_q;
	logic [20:0] rest;
	logic [51:0] kr_prod;
	logic [KRW-1:0] kr_q;

	logic        en, out_load;
	logic        vld_s1;
	logic [31:0] x_s1;
	logic        err_s1, le_s1;
	logic [30:0] d_s1, d_s2;
	logic [61:0] dvd_s3, kd_prod;
	logic [KDW-1:0] kd_s3;

	logic [34:0] lx_s33, lr_s33, diff_s34;
	logic [2*MW-1:0] ln_p, fl_p, ep;
	logic [33:0] lnv;
	logic [30:0] flog_s41;
	logic [30:0] e_s88;
	logic [31:0] mag_s92;

	logic           vld_dly  [0:FLG_DLY-1];
	logic [1:0]     flg_dly  [0:FLG_DLY-1];
	logic [30:0]    flog_dly [0:LOG_DLY-1];
	logic [KDW-1:0] kd_dly   [0:KD_DLY-1];

	logic        vld_s92, err_s92, le_s92;
	logic [30:0] flog_s92;
	logic [31:0] sel;

	logic        out_vld_q, err_q, le_q;
	logic [31:0] force_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 31'd983040;
			wr_q <= 20'd6554;
			cr_q <= 20'd32768;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lewrf_pkg::REG_SPRING_STIFFNESS: k_q  <= cfg_data[30:0];
				lewrf_pkg::REG_WALL_RADIUS:      wr_q <= cfg_data[19:0];
				lewrf_pkg::REG_CELL_RADIUS:      cr_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	assign rest    = {1'b0, wr_q} + {1'b0, cr_q};
	assign kr_prod = k_q * rest;

	always_ff @(posedge clk) begin
		kr_q <= kr_prod[51:FB];
	end

	assign out_load      = !out_vld_q || m_axis_tready;
	assign en            = out_load || !vld_s92;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	assign err_s1 = x_s1[31] || (x_s1 == 32'd0);
	assign le_s1  = {1'b0, x_s1[30:0]} <= {11'd0, rest};
	assign d_s1   = x_s1[30:0] - {10'd0, rest};
	assign kd_prod = k_q * d_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= s_axis_tdata;
			d_s2   <= d_s1;
			dvd_s3 <= d_s2 * lewrf_pkg::C18_Q30;
			kd_s3  <= kd_prod[61:FB];
		end
	end

	// compression branch: k*R*ln(R/x)
	lewrf_log2 u_log_x (
		.clk (clk),
		.en  (en),
		.v   (x_s1[30:0]),
		.lg  (lx_s33)
	);

	lewrf_log2 u_log_r (
		.clk (clk),
		.en  (en),
		.v   ({10'd0, rest}),
		.lg  (lr_s33)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s34 <= (lr_s33 > lx_s33) ? lr_s33 - lx_s33 : '0;
		end
	end

	lewrf_mul u_mul_ln (
		.clk (clk),
		.en  (en),
		.a   (MW'(diff_s34)),
		.b   (MW'(lewrf_pkg::LN2_Q30)),
		.p   (ln_p)
	);

	assign lnv = ln_p[63:30];

	lewrf_mul u_mul_log (
		.clk (clk),
		.en  (en),
		.a   (MW'(kr_q)),
		.b   (MW'(lnv)),
		.p   (fl_p)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flog_s41 <= (|fl_p[2*MW-1:61]) ? '1 : fl_p[60:30];
		end
	end

	// tension branch: -k*d*exp(-1.8*d/R)
	lewrf_exp u_exp (
		.clk  (clk),
		.en   (en),
		.dvd  (dvd_s3),
		.rest (rest),
		.e    (e_s88)
	);

	lewrf_mul u_mul_exp (
		.clk (clk),
		.en  (en),
		.a   (MW'(kd_dly[KD_DLY-1])),
		.b   (MW'(e_s88)),
		.p   (ep)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if ((|ep[2*MW-1:62]) || (ep[61:30] > 32'h80000000)) begin
				mag_s92 <= 32'h80000000;
			end else begin
				mag_s92 <= ep[61:30];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FLG_DLY; i++) begin
				vld_dly[i] <= 1'b0;
			end
		end else if (en) begin
			vld_dly[0] <= vld_s1;
			for (int i = 1; i < FLG_DLY; i++) begin
				vld_dly[i] <= vld_dly[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_dly[0]  <= {err_s1, le_s1};
			flog_dly[0] <= flog_s41;
			kd_dly[0]   <= kd_s3;
			for (int i = 1; i < FLG_DLY; i++) begin
				flg_dly[i] <= flg_dly[i-1];
			end
			for (int i = 1; i < LOG_DLY; i++) begin
				flog_dly[i] <= flog_dly[i-1];
			end
			for (int i = 1; i < KD_DLY; i++) begin
				kd_dly[i] <= kd_dly[i-1];
			end
		end
	end

	assign vld_s92  = vld_dly[FLG_DLY-1];
	assign err_s92  = flg_dly[FLG_DLY-1][1];
	assign le_s92   = flg_dly[FLG_DLY-1][0];
	assign flog_s92 = flog_dly[LOG_DLY-1];

	always_comb begin
		if (err_s92) begin
			sel = 32'h7FFFFFFF;
		end else if (le_s92) begin
			sel = {1'b0, flog_s92};
		end else begin
			sel = ~mag_s92 + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= vld_s92;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			force_q <= sel;
			err_q   <= err_s92;
			le_q    <= le_s92;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = force_q;
	assign m_axis_tuser  = err_q;

	`LEWRF_ASSERT(a_err_max, (out_vld_q && err_q) |-> (force_q == 32'h7FFFFFFF), "domain error without max force")
	`LEWRF_ASSERT(a_log_sign, (out_vld_q && !err_q && le_q) |-> !force_q[31], "negative force in compression")
	`LEWRF_ASSERT(a_exp_sign, (out_vld_q && !err_q && !le_q) |-> (force_q[31] || force_q == 32'd0), "positive force in tension")
	`LEWRF_ASSERT_NEXT(a_hold, (out_vld_q && !m_axis_tready && vld_s92), ($stable(vld_s1) && out_vld_q), "pipeline moved while output held")

endmodule

@@ hdl/lewrf_log2.sv @@
// Pipelined log2 with 30 fraction bits: normalize, then 30 squaring stages.
// Uses lewrf_pkg for nothing but keeps the shared style; no submodules.
module lewrf_log2 (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] v,
	output logic [34:0] lg
);

	logic [4:0]  msb;
	logic [4:0]  p_s1;
	logic [30:0] v_s1;
	logic [4:0]  p_s  [0:30];
	logic [30:0] m_s  [0:30];
	logic [29:0] f_s  [0:30];

	always_comb begin
		msb = '0;
		for (int i = 0; i < 31; i++) begin
			if (v[i]) begin
				msb = 5'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= msb;
			v_s1 <= v;
			p_s[0] <= p_s1;
			m_s[0] <= 31'(v_s1 << (5'd30 - p_s1));
			f_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < 30; i++) begin : g_sq
		logic [61:0] prod;
		logic [31:0] sq;
		assign prod = m_s[i] * m_s[i];
		assign sq   = prod[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[i+1] <= p_s[i];
				m_s[i+1] <= sq[31] ? sq[31:1] : sq[30:0];
				f_s[i+1] <= {f_s[i][28:0], sq[31]};
			end
		end
	end

	assign lg = {p_s[30], f_s[30]};

endmodule

@@ hdl/lewrf_mul.sv @@
// Three-stage 48x48 unsigned multiplier built from 24x24 partial products.
// Depends on lewrf_pkg for the operand width.
module lewrf_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [lewrf_pkg::MUL_W-1:0]   a,
	input  logic [lewrf_pkg::MUL_W-1:0]   b,
	output logic [2*lewrf_pkg::MUL_W-1:0] p
);

	localparam int H = lewrf_pkg::MUL_HALF;
	localparam int W = lewrf_pkg::MUL_W;

	logic [W-1:0]   ll_s1, lh_s1, ll_s2, lh_s2, hl_s2, hh_s2;
	logic [H-1:0]   ah_s1, bl_s1, bh_s1;
	logic [2*W-1:0] p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[H-1:0] * b[H-1:0];
			lh_s1 <= a[H-1:0] * b[W-1:H];
			ah_s1 <= a[W-1:H];
			bl_s1 <= b[H-1:0];
			bh_s1 <= b[W-1:H];
			ll_s2 <= ll_s1;
			lh_s2 <= lh_s1;
			hl_s2 <= ah_s1 * bl_s1;
			hh_s2 <= ah_s1 * bh_s1;
			p_s3  <= (2*W)'(ll_s2) + ((2*W)'(lh_s2) << H) + ((2*W)'(hl_s2) << H)
				+ {hh_s2, {W{1'b0}}};
		end
	end

	assign p = p_s3;

endmodule

@@ hdl/lewrf_exp.sv @@
// exp(-d*1.8/R) pipeline: restoring divider, ln2 range reduction, Taylor series.
// Depends on lewrf_pkg for ln2 and 1.0.
module lewrf_exp (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] dvd,
	input  logic [20:0] rest,
	output logic [30:0] e
);

	typedef struct packed {
		logic [29:0]        r;
		logic [5:0]         n;
		logic               ovf;
		logic signed [31:0] sum;
	} tay_side_t;

	logic [20:0] dv_rem_s [0:35];
	logic [34:0] dv_low_s [0:35];
	logic        dv_ovf_s [0:35];

	logic [34:0] rd_r_s   [0:5];
	logic [5:0]  rd_n_s   [0:5];
	logic        rd_ovf_s [0:5];

	logic [29:0] a_t_s    [1:14];
	tay_side_t   a_side_s [1:14];
	logic [29:0] b_t_s    [1:14];
	logic [29:0] b_q_s    [1:14];
	tay_side_t   b_side_s [1:14];
	logic [30:0] c_term_s [1:14];
	tay_side_t   c_side_s [1:14];

	tay_side_t   fs;
	logic [30:0] e_s;

	// quotient of 2^35 or more means exp underflows to zero
	always_ff @(posedge clk) begin
		if (en) begin
			dv_ovf_s[0] <= dvd[61:35] >= {6'd0, rest};
			dv_rem_s[0] <= dvd[55:35];
			dv_low_s[0] <= dvd[34:0];
		end
	end

	for (genvar j = 0; j < 35; j++) begin : g_div
		logic [21:0] t, df;
		logic        ge;
		assign t  = {dv_rem_s[j], dv_low_s[j][34]};
		assign ge = t >= {1'b0, rest};
		assign df = t - {1'b0, rest};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j+1] <= ge ? df[20:0] : t[20:0];
				dv_low_s[j+1] <= {dv_low_s[j][33:0], ge};
				dv_ovf_s[j+1] <= dv_ovf_s[j];
			end
		end
	end

	for (genvar j = 0; j < 6; j++) begin : g_red
		localparam logic [34:0] CMP = {5'd0, lewrf_pkg::LN2_Q30} << (5 - j);
		logic [34:0] r_in;
		logic [5:0]  n_in;
		logic        ovf_in, ge;
		if (j == 0) begin : g_src
			assign r_in   = dv_low_s[35];
			assign n_in   = '0;
			assign ovf_in = dv_ovf_s[35];
		end else begin : g_src
			assign r_in   = rd_r_s[j-1];
			assign n_in   = rd_n_s[j-1];
			assign ovf_in = rd_ovf_s[j-1];
		end
		assign ge = r_in >= CMP;
		always_ff @(posedge clk) begin
			if (en) begin
				rd_r_s[j]   <= ge ? r_in - CMP : r_in;
				rd_n_s[j]   <= {n_in[4:0], ge};
				rd_ovf_s[j] <= ovf_in;
			end
		end
	end

	for (genvar k = 1; k <= 14; k++) begin : g_tay
		localparam logic [32:0] RCP = 33'((64'd1 << 32) / k);
		localparam logic [3:0]  KC  = 4'(k);
		localparam bit          ODD = (k % 2) == 1;
		logic [30:0] src_term;
		tay_side_t   src_side, nxt;
		logic [60:0] pa;
		logic [62:0] pb;
		logic [33:0] qk, rm;
		logic        ge;
		logic [30:0] term_n;

		if (k == 1) begin : g_src
			assign src_term = lewrf_pkg::Q30_ONE;
			assign src_side = {rd_r_s[5][29:0], rd_n_s[5], rd_ovf_s[5], 32'sd1073741824};
		end else begin : g_src
			assign src_term = c_term_s[k-1];
			assign src_side = c_side_s[k-1];
		end

		assign pa = src_term * src_side.r;
		assign pb = a_t_s[k] * RCP;

		// reciprocal estimate is low by at most one
		assign qk     = b_q_s[k] * KC;
		assign rm     = {4'd0, b_t_s[k]} - qk;
		assign ge     = rm >= 34'(k);
		assign term_n = {1'b0, b_q_s[k]} + {30'd0, ge};

		always_comb begin
			nxt = b_side_s[k];
			if (ODD) begin
				nxt.sum = b_side_s[k].sum - $signed({1'b0, term_n});
			end else begin
				nxt.sum = b_side_s[k].sum + $signed({1'b0, term_n});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_t_s[k]    <= pa[59:30];
				a_side_s[k] <= src_side;
				b_q_s[k]    <= pb[61:32];
				b_t_s[k]    <= a_t_s[k];
				b_side_s[k] <= a_side_s[k];
				c_term_s[k] <= term_n;
				c_side_s[k] <= nxt;
			end
		end
	end

	assign fs = c_side_s[14];

	always_ff @(posedge clk) begin
		if (en) begin
			if (fs.ovf || fs.n >= 6'd31 || fs.sum[31]) begin
				e_s <= '0;
			end else begin
				e_s <= fs.sum[30:0] >> fs.n;
			end
		end
	end

	assign e = e_s;

endmodule

@@ sim/wall_force_checker.sv @@
// Checker for the log/exp wall force pipeline: tracks register writes, predicts
// each force result from accepted positions and compares transfers in order.
// Depends on lewrf_pkg.
module wall_force_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [31:0] force_x;
		logic        domain_error;
	} force_t;

	localparam logic [63:0] LN2 = 64'd744261118;
	localparam logic [63:0] C18 = 64'd1932735283;
	localparam logic [63:0] ONE = 64'd1 << 30;
	localparam logic [63:0] ALL_ONES = {64{1'b1}};

	logic [30:0] stiff;
	logic [19:0] wall_r;
	logic [19:0] cell_r;
	force_t force_q[$];

	function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b,
			int s, logic [63:0] cap);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		if (p[127:64] != 0) return cap;
		return (p[63:0] > cap) ? cap : p[63:0];
	endfunction

	function automatic logic [63:0] log2_fx(logic [63:0] v);
		int msb;
		logic [63:0] m;
		logic [63:0] frac;
		msb = 0;
		frac = 0;
		if (v == 0) return 0;
		while (msb < 63 && (v >> (msb + 1)) != 0) msb++;
		m = (msb <= 30) ? (v << (30 - msb)) : (v >> (msb - 30));
		for (int i = 0; i < 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (ONE << 1)) begin
				frac[29 - i] = 1'b1;
				m = m >> 1;
			end
		end
		return (64'(msb) << 30) | frac;
	endfunction

	function automatic logic [63:0] exp_neg(logic [63:0] y);
		logic [63:0] n, r, term;
		longint sum;
		if (y >= (64'd32 << 30)) return 0;
		n = y / LN2;
		r = y - n * LN2;
		term = ONE;
		sum = longint'(ONE);
		for (int k = 1; k <= 14; k++) begin
			term = ((term * r) >> 30) / k;
			if (k % 2) sum -= longint'(term);
			else sum += longint'(term);
		end
		if (sum < 0) sum = 0;
		if (n >= 31) return 0;
		return 64'(sum) >> n;
	endfunction

	function automatic force_t wall_force(logic [31:0] pos);
		force_t f;
		longint x;
		logic [63:0] rest, lr, lx, diff, lnv, kr, d, e, kd, mag;
		x = longint'(signed'(pos));
		rest = 64'(wall_r) + 64'(cell_r);
		f.domain_error = 1'b0;
		if (x <= 0) begin
			f.force_x = 32'h7fffffff;
			f.domain_error = 1'b1;
		end else if (64'(x) <= rest) begin
			lr = log2_fx(rest);
			lx = log2_fx(64'(x));
			diff = (lr > lx) ? lr - lx : 0;
			lnv = mul_shift_sat(diff, LN2, 30, ALL_ONES);
			kr = mul_shift_sat(64'(stiff), rest, lewrf_pkg::FRAC_BITS, ALL_ONES);
			f.force_x = 32'(mul_shift_sat(kr, lnv, 30, 64'h7fffffff));
		end else begin
			d = 64'(x) - rest;
			e = (rest != 0) ? exp_neg((d * C18) / rest) : 0;
			kd = mul_shift_sat(64'(stiff), d, lewrf_pkg::FRAC_BITS, ALL_ONES);
			mag = mul_shift_sat(kd, e, 30, 64'd1 << 31);
			f.force_x = 32'(-mag);
		end
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		force_t want;
		if (!arst_n) begin
			stiff <= 31'd983040;
			wall_r <= 20'd6554;
			cell_r <= 20'd32768;
			fail_count <= 0;
			pending <= 0;
			force_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lewrf_pkg::REG_SPRING_STIFFNESS: stiff <= cfg_data[30:0];
					lewrf_pkg::REG_WALL_RADIUS: wall_r <= cfg_data[19:0];
					lewrf_pkg::REG_CELL_RADIUS: cell_r <= cfg_data[19:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				force_q.push_back(wall_force(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (force_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer force=%h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = force_q.pop_front();
					if (want.force_x !== m_axis_tdata || want.domain_error !== m_axis_tuser[0]) begin
						if (fail_count < 10)
							$display("mismatch: force exp %h got %h, err exp %b got %b",
								want.force_x, m_axis_tdata, want.domain_error, m_axis_tuser[0]);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= force_q.size();
		end
	end
endmodule

@@ sim/tb.sv @@
// Testbench top for log_exp_wall_restoring_force: drives positions and register
// writes, stalls both sides at random. Depends on lewrf_pkg, wall_force_checker.
module tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = lewrf_pkg::REG_SPRING_STIFFNESS;
	logic [31:0] cfg_data = 0;
	int          fail_count;
	int          pending;
	bit          hold_off = 0;
	bit          stall_sink = 1;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	log_exp_wall_restoring_force dut (.*);

	wall_force_checker chk (.*);

	initial begin
		#50_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			gap = stall_sink ? $urandom_range(0, 5) : 0;
			if (gap != 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_position(logic [31:0] pos, int gap);
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= pos;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(lewrf_pkg::lewrf_reg_t idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_position(logic [20:0] rest_hint);
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return -$urandom_range(0, 1000);
			2: return $urandom_range(1, rest_hint + 1);
			3: return rest_hint + $urandom_range(0, rest_hint * 4 + 10);
			4: return $urandom_range(1, 300);
			default: return $urandom_range(1, 32'h000fffff);
		endcase
	endfunction

	initial begin
		logic [31:0] directed[$];
		logic [19:0] wr, cr;
		logic [30:0] k;
		int gap;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h1, 32'd39322,
			32'd39321, 32'd39323, 32'd20000, 32'd100000, 32'd2000000, 32'h00010000,
			32'd2, 32'h55555555, 32'haaaaaaaa};
		foreach (directed[i]) send_position(directed[i], $urandom_range(0, 2));
		drain();
		// zero rest length with extreme stiffness
		write_reg(lewrf_pkg::REG_WALL_RADIUS, 0);
		write_reg(lewrf_pkg::REG_CELL_RADIUS, 0);
		write_reg(lewrf_pkg::REG_SPRING_STIFFNESS, 32'h7fffffff);
		send_position(32'd1, 0);
		send_position(32'd5000, 0);
		send_position(32'hfff00000, 0);
		drain();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin k = 31'h7fffffff; wr = 20'hfffff; cr = 20'hfffff; end
				1: begin k = 1; wr = 1; cr = 1; end
				2: begin k = 31'd983040; wr = 20'd6554; cr = 20'd32768; end
				default: begin
					k = 31'($urandom_range(1, 32'h7fffffff) >> $urandom_range(0, 20));
					wr = 20'($urandom_range(1, 20'hfffff) >> $urandom_range(0, 12));
					cr = 20'($urandom_range(1, 20'hfffff) >> $urandom_range(0, 12));
					if (k == 0) k = 1;
				end
			endcase
			write_reg(lewrf_pkg::REG_SPRING_STIFFNESS, {1'b0, k});
			write_reg(lewrf_pkg::REG_WALL_RADIUS, {12'd0, wr});
			write_reg(lewrf_pkg::REG_CELL_RADIUS, {12'd0, cr});
			if (phase == 3) begin
				hold_off = 1;
				stall_sink = 0;
			end
			for (int i = 0; i < 100; i++) begin
				gap = (phase == 3 || i % 40 < 10) ? 0 : $urandom_range(0, 5);
				send_position(rand_position({1'b0, wr} + {1'b0, cr}), gap);
				if (i == 50) begin
					stall_sink = 1;
					s_axis_tvalid <= 0;
					while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/lewrf_pkg.sv
hdl/lewrf_log2.sv
hdl/lewrf_mul.sv
hdl/lewrf_exp.sv
hdl/log_exp_wall_restoring_force.sv
sim/wall_force_checker.sv
sim/tb.sv
